>>> rtl/reply_frame_checker_assert.svh
// Assertion macros used by the checker file rfc_checker.sv.
`ifndef REPLY_FRAME_CHECKER_ASSERT_SVH
`define REPLY_FRAME_CHECKER_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define RFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define RFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rfc_pkg.sv
`default_nettype none
package rfc_pkg;

    localparam int BYTE_W        = 8;
    localparam int MIN_FRAME_LEN = 6;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int M_TDATA_W     = 32;

    // fault flag bit positions
    localparam int FLT_HEADER  = 0;
    localparam int FLT_TAIL    = 1;
    localparam int FLT_DEVICE  = 2;
    localparam int FLT_SERVICE = 3;
    localparam int FLT_CSUM    = 4;
    localparam int FLT_W       = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ID   = 3'd0,
        CFG_FRAME_LEN   = 3'd1,
        CFG_SERVICE_LEN = 3'd2,
        CFG_SERVICE_IDS = 3'd3,
        CFG_VERIFY_CSUM = 3'd4,
        CFG_CHECK_TAIL  = 3'd5,
        CFG_HEADER_BYTE = 3'd6,
        CFG_TAIL_BYTE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_HEADER   = 3'd1,
        ERR_TAIL     = 3'd2,
        ERR_DEVICE   = 3'd3,
        ERR_SERVICE  = 3'd4,
        ERR_CHECKSUM = 3'd5
    } t_err;

    typedef struct packed {
        logic [7:0]  device_id;
        logic [3:0]  frame_len;
        logic [1:0]  service_len;
        logic [23:0] service_ids;
        logic        verify_checksum;
        logic        check_tail;
        logic [7:0]  header_byte;
        logic [7:0]  tail_byte;
    } t_cfg;

    // frame_ok sits in bit 0
    typedef struct packed {
        logic [7:0] payload_c;
        logic [7:0] payload_b;
        logic [7:0] payload_a;
        t_err       error_code;
        logic       frame_ok;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage
`default_nettype wire

>>> rtl/rfc_cfg_regs.sv
`default_nettype none
module rfc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire rfc_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rfc_pkg::t_cfg                       o_cfg
);

    rfc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id       <= 8'h00;
            r_cfg.frame_len       <= 4'd8;
            r_cfg.service_len     <= 2'd1;
            r_cfg.service_ids     <= 24'h000000;
            r_cfg.verify_checksum <= 1'b1;
            r_cfg.check_tail      <= 1'b1;
            r_cfg.header_byte     <= 8'h55;
            r_cfg.tail_byte       <= 8'hBB;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rfc_pkg::CFG_DEVICE_ID:   r_cfg.device_id       <= i_cfg_data[7:0];
                rfc_pkg::CFG_FRAME_LEN:   r_cfg.frame_len       <= i_cfg_data[3:0];
                rfc_pkg::CFG_SERVICE_LEN: r_cfg.service_len     <= i_cfg_data[1:0];
                rfc_pkg::CFG_SERVICE_IDS: r_cfg.service_ids     <= i_cfg_data[23:0];
                rfc_pkg::CFG_VERIFY_CSUM: r_cfg.verify_checksum <= i_cfg_data[0];
                rfc_pkg::CFG_CHECK_TAIL:  r_cfg.check_tail      <= i_cfg_data[0];
                rfc_pkg::CFG_HEADER_BYTE: r_cfg.header_byte     <= i_cfg_data[7:0];
                rfc_pkg::CFG_TAIL_BYTE:   r_cfg.tail_byte       <= i_cfg_data[7:0];
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/rfc_frame_core.sv
`default_nettype none
module rfc_frame_core #(
    parameter int MAX_FRAME_LEN = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rfc_pkg::t_cfg              i_cfg,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [rfc_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic                       i_in_start,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rfc_pkg::t_result                o_result
);

    localparam int PW = $clog2(MAX_FRAME_LEN);
    localparam int LW = $clog2(MAX_FRAME_LEN + 1);
    localparam int CW = (LW > 4) ? LW : 4;

    // input register
    logic                       r_in_valid;
    logic [rfc_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_start;

    // frame state
    logic [PW-1:0]              r_pos,   n_pos;
    logic [7:0]                 r_sum,   n_sum;
    logic [rfc_pkg::FLT_W-1:0]  r_flags, n_flags;
    logic [7:0]                 r_pay [3];
    logic [7:0]                 n_pay [3];

    // result register
    logic                       r_out_valid;
    rfc_pkg::t_result           r_result, n_result;

    logic                       w_out_free;
    logic                       w_proc;
    logic                       w_last;
    logic [PW-1:0]              w_pos;
    logic [LW-1:0]              w_pos_x;
    logic [CW-1:0]              w_flen_x;
    logic [CW-1:0]              w_len_c;
    logic [LW-1:0]              w_len;
    logic [7:0]                 w_sum_base;
    logic [rfc_pkg::FLT_W-1:0]  w_flags;
    logic [rfc_pkg::FLT_W-1:0]  w_flags_fin;
    rfc_pkg::t_err              w_code;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign w_proc      = r_in_valid && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        w_pos    = r_in_start ? '0 : r_pos;
        w_pos_x  = LW'(w_pos);
        w_flen_x = CW'(i_cfg.frame_len);
        if (w_flen_x < CW'(rfc_pkg::MIN_FRAME_LEN)) begin
            w_len_c = CW'(rfc_pkg::MIN_FRAME_LEN);
        end else if (w_flen_x > CW'(MAX_FRAME_LEN)) begin
            w_len_c = CW'(MAX_FRAME_LEN);
        end else begin
            w_len_c = w_flen_x;
        end
        w_len  = LW'(w_len_c);
        w_last = (w_pos_x >= (w_len - LW'(1)));

        // byte 0 opens a fresh frame
        w_sum_base = (w_pos_x == LW'(0)) ? 8'h00 : r_sum;
        w_flags    = (w_pos_x == LW'(0)) ? '0 : r_flags;

        if (w_pos_x == LW'(0) && r_in_byte != i_cfg.header_byte) begin
            w_flags[rfc_pkg::FLT_HEADER] = 1'b1;
        end
        if (w_pos_x == LW'(1) && r_in_byte != i_cfg.device_id) begin
            w_flags[rfc_pkg::FLT_DEVICE] = 1'b1;
        end
        if (w_pos_x == LW'(2) && i_cfg.service_len >= 2'd1
                && r_in_byte != i_cfg.service_ids[7:0]) begin
            w_flags[rfc_pkg::FLT_SERVICE] = 1'b1;
        end
        if (w_pos_x == LW'(3) && i_cfg.service_len >= 2'd2
                && r_in_byte != i_cfg.service_ids[15:8]) begin
            w_flags[rfc_pkg::FLT_SERVICE] = 1'b1;
        end
        if (w_pos_x == LW'(4) && i_cfg.service_len == 2'd3
                && r_in_byte != i_cfg.service_ids[23:16]) begin
            w_flags[rfc_pkg::FLT_SERVICE] = 1'b1;
        end
        if (w_pos_x == (w_len - LW'(2)) && r_in_byte != w_sum_base) begin
            w_flags[rfc_pkg::FLT_CSUM] = 1'b1;
        end
        if (w_last && r_in_byte != i_cfg.tail_byte) begin
            w_flags[rfc_pkg::FLT_TAIL] = 1'b1;
        end

        n_sum = w_sum_base;
        if (w_pos_x != LW'(0) && w_pos_x <= (w_len - LW'(3))) begin
            n_sum = w_sum_base + r_in_byte;
        end

        n_pay = r_pay;
        case (w_pos_x)
            LW'(3):  n_pay[0] = r_in_byte;
            LW'(4):  n_pay[1] = r_in_byte;
            LW'(5):  n_pay[2] = r_in_byte;
            default: ;
        endcase

        // enables for tail and checksum apply at the end of the frame
        w_flags_fin = w_flags;
        if (!i_cfg.check_tail) begin
            w_flags_fin[rfc_pkg::FLT_TAIL] = 1'b0;
        end
        if (!i_cfg.verify_checksum) begin
            w_flags_fin[rfc_pkg::FLT_CSUM] = 1'b0;
        end

        if (w_flags_fin[rfc_pkg::FLT_HEADER]) begin
            w_code = rfc_pkg::ERR_HEADER;
        end else if (w_flags_fin[rfc_pkg::FLT_TAIL]) begin
            w_code = rfc_pkg::ERR_TAIL;
        end else if (w_flags_fin[rfc_pkg::FLT_DEVICE]) begin
            w_code = rfc_pkg::ERR_DEVICE;
        end else if (w_flags_fin[rfc_pkg::FLT_SERVICE]) begin
            w_code = rfc_pkg::ERR_SERVICE;
        end else if (w_flags_fin[rfc_pkg::FLT_CSUM]) begin
            w_code = rfc_pkg::ERR_CHECKSUM;
        end else begin
            w_code = rfc_pkg::ERR_NONE;
        end

        n_result.frame_ok   = (w_code == rfc_pkg::ERR_NONE);
        n_result.error_code = w_code;
        n_result.payload_a  = n_pay[0];
        n_result.payload_b  = n_pay[1];
        n_result.payload_c  = n_pay[2];

        if (w_last) begin
            n_pos   = '0;
            n_sum   = 8'h00;
            n_flags = '0;
        end else begin
            n_pos   = w_pos + PW'(1);
            n_flags = w_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_sum       <= 8'h00;
            r_flags     <= '0;
            r_pay[0]    <= 8'h00;
            r_pay[1]    <= 8'h00;
            r_pay[2]    <= 8'h00;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_proc && w_last;
            end
            if (w_proc) begin
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_flags <= n_flags;
                r_pay   <= n_pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_in_start;
        end
        if (w_proc && w_last) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

>>> rtl/reply_frame_checker.sv
`default_nettype none
// Reply frame checker: takes one received byte per beat on the slave stream and,
// on the last byte of each fixed-length frame, delivers one result beat with the
// pass flag, the highest-priority failing check and frame bytes 3 to 5. A new
// byte is accepted every cycle while ready is high; a byte is registered in the
// input register on acceptance and checked against the configuration once the
// output register is free, and the frame's result is then held in the output
// register. The single output register sets the stall behavior: ready drops
// only while a result is held and not taken and a byte already waits in the
// input register. Configuration writes complete in the cycle they are offered.
module reply_frame_checker #(
    parameter int MAX_FRAME_LEN = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rfc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // received bytes
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,   // [7:0] rx_byte
    input  wire logic                              i_s_tuser,   // [0] frame_start
    // frame results
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [0] frame_ok, [3:1] error_code, [11:4] payload_a, [19:12] payload_b,
    // [27:20] payload_c, [31:28] zero
    output logic [rfc_pkg::M_TDATA_W-1:0]          o_m_tdata
);

    rfc_pkg::t_cfg    w_cfg;
    rfc_pkg::t_result w_result;

    rfc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (rfc_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rfc_frame_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_frame_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_in_byte   (i_s_tdata),
        .i_in_start  (i_s_tuser),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_result    (w_result)
    );

    assign o_m_tdata = {{(rfc_pkg::M_TDATA_W - rfc_pkg::RESULT_W){1'b0}}, w_result};

endmodule
`default_nettype wire

>>> rtl/rfc_checker.sv
`default_nettype none
`include "reply_frame_checker_assert.svh"
module rfc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [rfc_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    // hold a stalled result beat
    `RFC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled result beat changed")

    // pass flag agrees with the error code
    `RFC_ASSERT(a_ok_code, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[3:1] == rfc_pkg::ERR_NONE)), "frame_ok disagrees with error_code")

    // only defined error codes leave the block
    `RFC_ASSERT(a_code_range, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[3:1] <= rfc_pkg::ERR_CHECKSUM), "undefined error code")

    // input stalls only behind a held result beat
    `RFC_ASSERT(a_in_stall, i_clk, i_rst_n, (i_s_tvalid && !o_s_tready) |-> (o_m_tvalid && !i_m_tready), "input stalled without a held result")

    // reset empties the result register
    `RFC_ASSERT_ALWAYS(a_rst_clear, i_clk, (!i_rst_n) |=> !o_m_tvalid, "result valid after reset")

endmodule

bind reply_frame_checker rfc_checker u_rfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
